/* src/command_frame_to_servo_packet_defines.svh */
// assertion macros shared by the rtl files
`ifndef COMMAND_FRAME_TO_SERVO_PACKET_DEFINES_SVH
`define COMMAND_FRAME_TO_SERVO_PACKET_DEFINES_SVH

`ifndef SYNTH

// condition must hold at every edge out of reset
`define CFSP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: always");

// antecedent in one cycle implies consequent in the next
`define CFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next");

`else

`define CFSP_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define CFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/cfsp_pkg.sv */
package cfsp_pkg;

    // host command characters
    localparam logic [7:0] CH_OPEN  = 8'h24;
    localparam logic [7:0] CH_CLOSE = 8'h3B;
    localparam logic [7:0] CH_WRITE = 8'h41;

    // servo packet constants
    localparam logic [7:0] PKT_HDR = 8'hFF;
    localparam logic [7:0] PKT_LEN = 8'h05;
    localparam logic [7:0] PKT_INS = 8'h03;

    // frame store holds positions 0..3
    localparam int STORE_DEPTH = 4;
    localparam int STORE_AW    = 2;

    // config register indexes and reset values
    localparam logic CFG_SERVO_ID  = 1'b0;
    localparam logic CFG_CTRL_ADDR = 1'b1;
    localparam logic [7:0] SERVO_ID_RST  = 8'd6;
    localparam logic [7:0] CTRL_ADDR_RST = 8'h1E;

    // output ports
    localparam logic PORT_HOST  = 1'b0;
    localparam logic PORT_SERVO = 1'b1;

    // command queue
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // packet byte sequence steps
    localparam logic [3:0] STEP_HDR0 = 4'd1;
    localparam logic [3:0] STEP_HDR1 = 4'd2;
    localparam logic [3:0] STEP_ID   = 4'd3;
    localparam logic [3:0] STEP_LEN  = 4'd4;
    localparam logic [3:0] STEP_INS  = 4'd5;
    localparam logic [3:0] STEP_ADDR = 4'd6;
    localparam logic [3:0] STEP_LO   = 4'd7;
    localparam logic [3:0] STEP_HI   = 4'd8;
    localparam logic [3:0] STEP_CHK  = 4'd9;

    typedef struct packed {
        logic       wr;
        logic [7:0] echo;
        logic [7:0] lo;
        logic [7:0] hi;
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_PACKET
    } t_back_state;

endpackage

/* src/cfsp_front.sv */
module cfsp_front #(
    parameter int FRAME_BYTES = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_fifo_full,
    output logic              o_push,
    output cfsp_pkg::t_cmd    o_cmd
);

    localparam int IW = $clog2(FRAME_BYTES + 1);

    logic [7:0]    r_store [cfsp_pkg::STORE_DEPTH];
    logic [7:0]    n_store [cfsp_pkg::STORE_DEPTH];
    logic [IW-1:0] r_widx, n_widx;
    logic          r_in_frame, n_in_frame;

    logic          accept, is_open, is_close, in_f;
    logic [IW-1:0] widx_eff;

    assign o_rx_ready = !i_fifo_full;
    assign accept     = i_rx_valid && o_rx_ready;
    assign is_open    = (i_rx_byte == cfsp_pkg::CH_OPEN);
    assign is_close   = (i_rx_byte == cfsp_pkg::CH_CLOSE);
    assign in_f       = is_open || r_in_frame;
    assign widx_eff   = is_open ? '0 : r_widx;

    always_comb begin
        n_store    = r_store;
        n_widx     = r_widx;
        n_in_frame = r_in_frame;
        if (accept) begin
            n_in_frame = in_f;
            n_widx     = widx_eff;
            if (in_f && (widx_eff < IW'(FRAME_BYTES))) begin
                if (widx_eff < IW'(cfsp_pkg::STORE_DEPTH)) begin
                    n_store[widx_eff[cfsp_pkg::STORE_AW-1:0]] = i_rx_byte;
                end
                n_widx = widx_eff + IW'(1);
            end
            if (is_close) begin
                n_in_frame = 1'b0;
                n_widx     = '0;
            end
        end
    end

    // command built from the store as it stands after this byte
    assign o_push     = accept && is_close;
    assign o_cmd.echo = n_store[1];
    assign o_cmd.wr   = (n_store[1] == cfsp_pkg::CH_WRITE);
    assign o_cmd.lo   = n_store[3];
    assign o_cmd.hi   = n_store[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cfsp_pkg::STORE_DEPTH; k++) begin
                r_store[k] <= '0;
            end
            r_widx     <= '0;
            r_in_frame <= 1'b0;
        end else begin
            r_store    <= n_store;
            r_widx     <= n_widx;
            r_in_frame <= n_in_frame;
        end
    end

endmodule

/* src/cfsp_fifo.sv */
`include "command_frame_to_servo_packet_defines.svh"

module cfsp_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cfsp_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output cfsp_pkg::t_cmd o_head
);

    cfsp_pkg::t_cmd                r_mem [cfsp_pkg::FIFO_DEPTH];
    logic [cfsp_pkg::FIFO_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [cfsp_pkg::FIFO_CW-1:0]  r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == cfsp_pkg::FIFO_CW'(cfsp_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [cfsp_pkg::FIFO_AW-1:0] ptr_inc(
        input logic [cfsp_pkg::FIFO_AW-1:0] p
    );
        if (p == cfsp_pkg::FIFO_AW'(cfsp_pkg::FIFO_DEPTH - 1)) begin
            return '0;
        end
        return p + cfsp_pkg::FIFO_AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + cfsp_pkg::FIFO_CW'(1);
                2'b01:   r_count <= r_count - cfsp_pkg::FIFO_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // no request is pushed into a full queue or popped from an empty one
    `CFSP_ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full))
    `CFSP_ASSERT_ALWAYS(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_empty))
    // occupancy and pointers agree
    `CFSP_ASSERT_ALWAYS(a_ptr_match, i_clk, i_rst_n,
        ((r_count == '0) || o_full) == (r_wr_ptr == r_rd_ptr))

endmodule

/* src/cfsp_back.sv */
`include "command_frame_to_servo_packet_defines.svh"

module cfsp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  cfsp_pkg::t_cmd i_head,
    output logic           o_pop,
    input  logic [7:0]     i_servo_id,
    input  logic [7:0]     i_ctrl_addr,
    output logic           o_tx_valid,
    input  logic           i_tx_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_out_port,
    output logic           o_last
);

    cfsp_pkg::t_back_state r_state, n_state;
    logic [3:0]     r_step, n_step;
    cfsp_pkg::t_cmd r_cmd, n_cmd;
    logic           r_valid, n_valid;
    logic [7:0]     r_byte, n_byte;
    logic           r_port, n_port;
    logic           r_last, n_last;

    logic       adv;
    logic [7:0] chk;
    logic [7:0] pkt_byte;

    assign adv = !r_valid || i_tx_ready;
    assign chk = ~(i_servo_id + cfsp_pkg::PKT_LEN + cfsp_pkg::PKT_INS
                   + i_ctrl_addr + r_cmd.lo + r_cmd.hi);

    always_comb begin
        case (r_step)
            cfsp_pkg::STEP_HDR0: pkt_byte = cfsp_pkg::PKT_HDR;
            cfsp_pkg::STEP_HDR1: pkt_byte = cfsp_pkg::PKT_HDR;
            cfsp_pkg::STEP_ID:   pkt_byte = i_servo_id;
            cfsp_pkg::STEP_LEN:  pkt_byte = cfsp_pkg::PKT_LEN;
            cfsp_pkg::STEP_INS:  pkt_byte = cfsp_pkg::PKT_INS;
            cfsp_pkg::STEP_ADDR: pkt_byte = i_ctrl_addr;
            cfsp_pkg::STEP_LO:   pkt_byte = r_cmd.lo;
            cfsp_pkg::STEP_HI:   pkt_byte = r_cmd.hi;
            cfsp_pkg::STEP_CHK:  pkt_byte = chk;
            default:             pkt_byte = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_cmd   = r_cmd;
        n_valid = r_valid;
        n_byte  = r_byte;
        n_port  = r_port;
        n_last  = r_last;
        o_pop   = 1'b0;
        case (r_state)
            cfsp_pkg::BK_IDLE: begin
                if (adv) begin
                    n_valid = !i_empty;
                    if (!i_empty) begin
                        o_pop  = 1'b1;
                        n_cmd  = i_head;
                        n_byte = i_head.echo;
                        n_port = cfsp_pkg::PORT_HOST;
                        n_last = !i_head.wr;
                        if (i_head.wr) begin
                            n_state = cfsp_pkg::BK_PACKET;
                            n_step  = cfsp_pkg::STEP_HDR0;
                        end
                    end
                end
            end
            cfsp_pkg::BK_PACKET: begin
                if (adv) begin
                    n_valid = 1'b1;
                    n_byte  = pkt_byte;
                    n_port  = cfsp_pkg::PORT_SERVO;
                    n_last  = (r_step == cfsp_pkg::STEP_CHK);
                    if (r_step == cfsp_pkg::STEP_CHK) begin
                        n_state = cfsp_pkg::BK_IDLE;
                    end else begin
                        n_step = r_step + 4'd1;
                    end
                end
            end
            default: begin
                n_state = cfsp_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfsp_pkg::BK_IDLE;
            r_step  <= cfsp_pkg::STEP_HDR0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_byte <= n_byte;
        r_port <= n_port;
        r_last <= n_last;
    end

    assign o_tx_valid = r_valid;
    assign o_out_byte = r_byte;
    assign o_out_port = r_port;
    assign o_last     = r_last;

    // a lone echo is never the write command
    `CFSP_ASSERT_ALWAYS(a_echo_last, i_clk, i_rst_n,
        !(r_valid && (r_port == cfsp_pkg::PORT_HOST) && r_last
          && (r_byte == cfsp_pkg::CH_WRITE)))
    // while sending a packet the step stays within the packet bytes
    `CFSP_ASSERT_ALWAYS(a_step_range, i_clk, i_rst_n,
        (r_state != cfsp_pkg::BK_PACKET)
        || ((r_step >= cfsp_pkg::STEP_HDR0) && (r_step <= cfsp_pkg::STEP_CHK)))
    // no queue pop while a packet is under way
    `CFSP_ASSERT_NEXT(a_no_pop_busy, i_clk, i_rst_n,
        (r_state == cfsp_pkg::BK_PACKET) && (r_step != cfsp_pkg::STEP_CHK), !o_pop)

endmodule

/* src/command_frame_to_servo_packet.sv */
// channel   direction  handshake                    payload
// rx        in         i_rx_valid / o_rx_ready      i_rx_byte
// tx        out        o_tx_valid / i_tx_ready      o_out_byte, o_out_port, o_last
// cfg       in         i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
// one rx request is taken per cycle while the command queue has room
// each ';' yields 1 tx byte (echo only) or 10 tx bytes (echo plus write packet),
// one per cycle while i_tx_ready is high, paced by the back-end byte sequencer
// the two-entry command queue lets rx run on while tx is stalled
// synchronous active-low reset, no start-up sweep

module command_frame_to_servo_packet #(
    parameter int FRAME_BYTES = 9
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // host byte input
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    // transmit byte output
    output logic       o_tx_valid,
    input  logic       i_tx_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_port,
    output logic       o_last,
    // configuration writes
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    // configuration registers
    logic [7:0] r_servo_id;
    logic [7:0] r_ctrl_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_servo_id  <= cfsp_pkg::SERVO_ID_RST;
            r_ctrl_addr <= cfsp_pkg::CTRL_ADDR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cfsp_pkg::CFG_SERVO_ID:  r_servo_id  <= i_cfg_data;
                cfsp_pkg::CFG_CTRL_ADDR: r_ctrl_addr <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front to queue
    logic           push;
    cfsp_pkg::t_cmd push_cmd;
    // queue to back
    logic           fifo_full, fifo_empty, pop;
    cfsp_pkg::t_cmd head_cmd;

    // front end: frame tracking and command capture on ';'
    cfsp_front #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .i_fifo_full (fifo_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // short command queue decoupling the two sides
    cfsp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (fifo_full),
        .o_empty (fifo_empty),
        .o_head  (head_cmd)
    );

    // back end: echo byte then optional servo packet through an output register
    cfsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (fifo_empty),
        .i_head      (head_cmd),
        .o_pop       (pop),
        .i_servo_id  (r_servo_id),
        .i_ctrl_addr (r_ctrl_addr),
        .o_tx_valid  (o_tx_valid),
        .i_tx_ready  (i_tx_ready),
        .o_out_byte  (o_out_byte),
        .o_out_port  (o_out_port),
        .o_last      (o_last)
    );

endmodule
